// File: rtl/mbc_pkg.sv
package mbc_pkg;

  localparam int TEMPO_W = 10;
  localparam int BEATS_W = 4;
  localparam int STEP_W = 5;
  localparam int HALF_W = 15;
  localparam int PRESS_W = 10;
  localparam int HOLD_W = 10;
  localparam int REP_W = 2;
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam int HALF_MINUTE_TICKS_DEF = 30000;

  localparam logic [TEMPO_W-1:0] TEMPO_RESET = 10'd120;
  localparam logic [BEATS_W-1:0] BEATS_RESET = 4'd4;
  localparam logic [TEMPO_W-1:0] BPM_MAX_RESET = 10'd300;
  localparam logic [PRESS_W-1:0] REPEAT_RESET = 10'd100;
  localparam logic [HOLD_W-1:0] HOLDOFF_RESET = 10'd500;
  localparam logic [BEATS_W-1:0] MAX_BEATS_RESET = 4'd8;
  localparam logic [REP_W-1:0] REP_SAT = 2'd3;

  typedef enum logic [1:0] {
    REG_BPM_MAX,
    REG_REPEAT,
    REG_HOLDOFF,
    REG_MAX_BEATS
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_CHECK,
    ST_DIV,
    ST_BEAT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [TEMPO_W-1:0] bpm_max;
    logic [PRESS_W-1:0] repeat_ticks;
    logic [HOLD_W-1:0]  holdoff_ticks;
    logic [BEATS_W-1:0] max_beats;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic tick;
    logic div_start;
    logic load_half;
    logic beat;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic changed;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

// File: rtl/metronome_beat_controller.sv
// Channel   Ports                                     Direction
// input     in_valid in_ready in_button_down/up       one word per millisecond tick
// output    out_valid out_ready out_led_* out_tempo   one result word per input word
//           out_beats_per_bar out_toggled
// config    psel penable pwrite paddr pwdata prdata   APB-style register access
//
// A word steps through the tick, check, beat and emit states; on a tempo change a
// divide state waits while the serial divider computes the half-beat interval one
// bit per cycle. Synchronous reset on rst_n restores the control state and settings.
// A word is taken while the previous result still waits in the output register.
// A stalled output holds the next result in the controller until the register frees.
module metronome_beat_controller
  import mbc_pkg::*;
#(
  parameter int HALF_MINUTE_TICKS = HALF_MINUTE_TICKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_button_down,
  input  logic               in_button_up,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_led_one,
  output logic               out_led_two,
  output logic [TEMPO_W-1:0] out_tempo,
  output logic [BEATS_W-1:0] out_beats_per_bar,
  output logic               out_toggled,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  cfg_t    cfg_r, cfg_nxt;
  cmd_t    cmd;
  status_t sts;
  logic    wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_BPM_MAX:   cfg_nxt.bpm_max = pwdata[TEMPO_W-1:0];
        REG_REPEAT:    cfg_nxt.repeat_ticks = pwdata[PRESS_W-1:0];
        REG_HOLDOFF:   cfg_nxt.holdoff_ticks = pwdata[HOLD_W-1:0];
        REG_MAX_BEATS: cfg_nxt.max_beats = pwdata[BEATS_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_BPM_MAX:   prdata = APB_DW'(cfg_r.bpm_max);
      REG_REPEAT:    prdata = APB_DW'(cfg_r.repeat_ticks);
      REG_HOLDOFF:   prdata = APB_DW'(cfg_r.holdoff_ticks);
      REG_MAX_BEATS: prdata = APB_DW'(cfg_r.max_beats);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bpm_max <= BPM_MAX_RESET;
      cfg_r.repeat_ticks <= REPEAT_RESET;
      cfg_r.holdoff_ticks <= HOLDOFF_RESET;
      cfg_r.max_beats <= MAX_BEATS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mbc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  mbc_dp #(
    .HALF_MINUTE_TICKS(HALF_MINUTE_TICKS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg              (cfg_r),
    .in_button_down   (in_button_down),
    .in_button_up     (in_button_up),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_led_one      (out_led_one),
    .out_led_two      (out_led_two),
    .out_tempo        (out_tempo),
    .out_beats_per_bar(out_beats_per_bar),
    .out_toggled      (out_toggled)
  );

endmodule

// File: rtl/mbc_div.sv
module mbc_div
  import mbc_pkg::*;
#(
  parameter int HALF_MINUTE_TICKS = HALF_MINUTE_TICKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [TEMPO_W-1:0] divisor,
  output logic               busy,
  output logic [HALF_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(HALF_W + 1);
  localparam logic [HALF_W-1:0] DIVIDEND = HALF_W'(HALF_MINUTE_TICKS);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [HALF_W-1:0]  q_r, q_nxt;
  logic [TEMPO_W-1:0] rem_r, rem_nxt;
  logic [TEMPO_W-1:0] dvs_r, dvs_nxt;
  logic [TEMPO_W:0]   trial;
  logic [TEMPO_W:0]   diff;

  assign trial = {rem_r, q_r[HALF_W-1]};
  assign diff = trial - {1'b0, dvs_r};

  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    if (start) begin
      cnt_nxt = CNT_W'(HALF_W);
      q_nxt = DIVIDEND;
      rem_nxt = '0;
      dvs_nxt = (divisor != '0) ? divisor : TEMPO_W'(1);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[TEMPO_W-1:0];
        q_nxt = {q_r[HALF_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[TEMPO_W-1:0];
        q_nxt = {q_r[HALF_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quotient = q_r;

endmodule

// File: rtl/mbc_dp.sv
module mbc_dp
  import mbc_pkg::*;
#(
  parameter int HALF_MINUTE_TICKS = HALF_MINUTE_TICKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            sts,
  input  cfg_t               cfg,
  input  logic               in_button_down,
  input  logic               in_button_up,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_led_one,
  output logic               out_led_two,
  output logic [TEMPO_W-1:0] out_tempo,
  output logic [BEATS_W-1:0] out_beats_per_bar,
  output logic               out_toggled
);

  localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(HALF_MINUTE_TICKS / TEMPO_RESET);

  logic               down_r, down_nxt;
  logic               up_r, up_nxt;
  logic [TEMPO_W-1:0] tempo_r, tempo_nxt;
  logic [BEATS_W-1:0] beats_r, beats_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               phase_r, phase_nxt;
  logic [1:0]         led_r, led_nxt;
  logic [HALF_W-1:0]  half_r, half_nxt;
  logic [HALF_W-1:0]  tog_r, tog_nxt;
  logic [PRESS_W-1:0] spd_r, spd_nxt;
  logic [PRESS_W-1:0] spu_r, spu_nxt;
  logic [REP_W-1:0]   rcd_r, rcd_nxt;
  logic [REP_W-1:0]   rcu_r, rcu_nxt;
  logic [HOLD_W-1:0]  hold_r, hold_nxt;
  logic               skip_r, skip_nxt;
  logic               changed_r, changed_nxt;
  logic               toggled_r, toggled_nxt;
  logic               ovalid_r, ovalid_nxt;

  logic [PRESS_W-1:0] spd_inc, spu_inc;
  logic [TEMPO_W-1:0] lim, t1;
  logic               accd, accu, chgd, chgu;
  logic [BEATS_W-1:0] span_beats;
  logic [STEP_W-1:0]  span, step_inc;

  logic               div_busy;
  logic [HALF_W-1:0]  div_q;

  mbc_div #(
    .HALF_MINUTE_TICKS(HALF_MINUTE_TICKS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .divisor (tempo_r),
    .busy    (div_busy),
    .quotient(div_q)
  );

  assign lim = (cfg.bpm_max != '0) ? cfg.bpm_max : TEMPO_W'(1);
  assign spd_inc = (spd_r != '1) ? spd_r + PRESS_W'(1) : spd_r;
  assign spu_inc = (spu_r != '1) ? spu_r + PRESS_W'(1) : spu_r;
  assign accd = down_r && (spd_inc >= cfg.repeat_ticks);
  assign accu = up_r && (spu_inc >= cfg.repeat_ticks);
  assign chgd = accd && ((rcd_r == '0) || (rcd_r == REP_SAT));
  assign chgu = accu && ((rcu_r == '0) || (rcu_r == REP_SAT));
  assign t1 = (chgd && (tempo_r > TEMPO_W'(1))) ? tempo_r - TEMPO_W'(1) : tempo_r;
  assign span_beats = (beats_r != '0) ? beats_r : BEATS_W'(1);
  assign span = {span_beats, 1'b0};
  assign step_inc = step_r + STEP_W'(1);

  always_comb begin
    down_nxt = down_r;
    up_nxt = up_r;
    tempo_nxt = tempo_r;
    beats_nxt = beats_r;
    step_nxt = step_r;
    phase_nxt = phase_r;
    led_nxt = led_r;
    half_nxt = half_r;
    tog_nxt = tog_r;
    spd_nxt = spd_r;
    spu_nxt = spu_r;
    rcd_nxt = rcd_r;
    rcu_nxt = rcu_r;
    hold_nxt = hold_r;
    skip_nxt = skip_r;
    changed_nxt = changed_r;
    toggled_nxt = toggled_r;

    if (cmd.capture) begin
      down_nxt = in_button_down;
      up_nxt = in_button_up;
    end

    if (cmd.tick) begin
      tog_nxt = (tog_r != '1) ? tog_r + HALF_W'(1) : tog_r;
      spd_nxt = spd_inc;
      spu_nxt = spu_inc;
      toggled_nxt = 1'b0;
      changed_nxt = 1'b0;
      if (hold_r != '0) begin
        hold_nxt = hold_r - HOLD_W'(1);
        skip_nxt = 1'b1;
      end else begin
        skip_nxt = 1'b0;
        if (down_r && up_r) begin
          if ({1'b0, beats_r} + (BEATS_W+1)'(1) > {1'b0, cfg.max_beats}) begin
            beats_nxt = BEATS_W'(1);
          end else begin
            beats_nxt = beats_r + BEATS_W'(1);
          end
          step_nxt = '0;
          phase_nxt = 1'b0;
          led_nxt = '0;
          hold_nxt = cfg.holdoff_ticks;
        end
        if (down_r) begin
          if (accd) begin
            spd_nxt = '0;
            if (rcd_r != REP_SAT) rcd_nxt = rcd_r + REP_W'(1);
          end
        end else begin
          rcd_nxt = '0;
        end
        if (up_r) begin
          if (accu) begin
            spu_nxt = '0;
            if (rcu_r != REP_SAT) rcu_nxt = rcu_r + REP_W'(1);
          end
        end else begin
          rcu_nxt = '0;
        end
        if (chgu && (t1 < lim)) begin
          tempo_nxt = t1 + TEMPO_W'(1);
        end else begin
          tempo_nxt = t1;
        end
        changed_nxt = (chgd && (tempo_r > TEMPO_W'(1))) || (chgu && (t1 < lim));
      end
    end

    if (cmd.load_half) begin
      half_nxt = div_q;
    end

    if (cmd.beat && !skip_r && (tog_r >= half_r)) begin
      tog_nxt = '0;
      phase_nxt = !phase_r;
      if (step_r < STEP_W'(2)) begin
        led_nxt[0] = !phase_r;
      end else begin
        led_nxt[1] = !phase_r;
      end
      step_nxt = (step_inc >= span) ? '0 : step_inc;
      toggled_nxt = 1'b1;
    end
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (cmd.load_out) begin
      ovalid_nxt = 1'b1;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_r <= TEMPO_RESET;
      beats_r <= BEATS_RESET;
      step_r <= '0;
      phase_r <= 1'b0;
      led_r <= '0;
      half_r <= HALF_RESET;
      tog_r <= '0;
      spd_r <= '0;
      spu_r <= '0;
      rcd_r <= '0;
      rcu_r <= '0;
      hold_r <= '0;
      skip_r <= 1'b0;
      changed_r <= 1'b0;
      toggled_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      tempo_r <= tempo_nxt;
      beats_r <= beats_nxt;
      step_r <= step_nxt;
      phase_r <= phase_nxt;
      led_r <= led_nxt;
      half_r <= half_nxt;
      tog_r <= tog_nxt;
      spd_r <= spd_nxt;
      spu_r <= spu_nxt;
      rcd_r <= rcd_nxt;
      rcu_r <= rcu_nxt;
      hold_r <= hold_nxt;
      skip_r <= skip_nxt;
      changed_r <= changed_nxt;
      toggled_r <= toggled_nxt;
      ovalid_r <= ovalid_nxt;
    end
    down_r <= down_nxt;
    up_r <= up_nxt;
    if (cmd.load_out) begin
      out_led_one <= led_r[0];
      out_led_two <= led_r[1];
      out_tempo <= tempo_r;
      out_beats_per_bar <= beats_r;
      out_toggled <= toggled_r;
    end
  end

  assign out_valid = ovalid_r;
  assign sts.changed = changed_r;
  assign sts.div_busy = div_busy;
  assign sts.out_free = !ovalid_r || out_ready;

endmodule

// File: rtl/mbc_ctrl.sv
module mbc_ctrl
  import mbc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_TICK;
      ST_TICK:  state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = sts.changed ? ST_DIV : ST_BEAT;
      ST_DIV:   if (!sts.div_busy) state_nxt = ST_BEAT;
      ST_BEAT:  state_nxt = ST_EMIT;
      ST_EMIT:  if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_valid;
      end
      ST_TICK:  cmd.tick = 1'b1;
      ST_CHECK: cmd.div_start = sts.changed;
      ST_DIV:   cmd.load_half = !sts.div_busy;
      ST_BEAT:  cmd.beat = 1'b1;
      ST_EMIT:  cmd.load_out = sts.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/mbc_checker.sv
module mbc_checker
  import mbc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_led_one,
  input logic               out_led_two,
  input logic [TEMPO_W-1:0] out_tempo,
  input logic [BEATS_W-1:0] out_beats_per_bar,
  input logic               out_toggled
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tempo) && $stable(out_toggled)
      && $stable(out_beats_per_bar) && $stable(out_led_one) && $stable(out_led_two))
    else $error("Stalled result word changed.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Input word accepted while another was in progress.");

  a_fields_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tempo != '0) && (out_beats_per_bar != '0))
    else $error("Result word carries a zero tempo or bar length.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result word present after reset.");

endmodule

bind metronome_beat_controller mbc_checker u_mbc_checker (.*);

// File: tb/metronome_beat_controller_tb.sv
`timescale 1ns / 100ps

module metronome_beat_controller_tb;
  import mbc_pkg::*;

  typedef struct packed {
    logic down;
    logic up;
  } press_word_t;

  typedef struct packed {
    logic               led_one;
    logic               led_two;
    logic [TEMPO_W-1:0] tempo;
    logic [BEATS_W-1:0] beats;
    logic               toggled;
  } beat_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_button_down = 1'b0;
  logic in_button_up = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_led_one;
  logic out_led_two;
  logic [TEMPO_W-1:0] out_tempo;
  logic [BEATS_W-1:0] out_beats_per_bar;
  logic out_toggled;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  metronome_beat_controller dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_button_down(in_button_down),
    .in_button_up(in_button_up),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_led_one(out_led_one),
    .out_led_two(out_led_two),
    .out_tempo(out_tempo),
    .out_beats_per_bar(out_beats_per_bar),
    .out_toggled(out_toggled),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #1 clk = ~clk;

  // Predicted state of the controller and its configuration.
  cfg_t               cfg;
  logic [TEMPO_W-1:0] tempo_now;
  logic [BEATS_W-1:0] bar_len;
  logic [STEP_W-1:0]  bar_step;
  logic               beat_phase;
  logic [1:0]         led_state;
  logic [HALF_W-1:0]  half_beat;
  logic [HALF_W-1:0]  since_beat;
  logic [PRESS_W-1:0] since_press [2];
  logic [REP_W-1:0]   press_run [2];
  logic [HOLD_W-1:0]  combo_wait;

  press_word_t pending_words [$];
  beat_word_t  expected_beats [$];

  int mismatches = 0;
  int results_seen = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  logic [15:0] rx_cycle = '0;
  logic rx_go;
  press_word_t next_word;
  beat_word_t got_word;
  beat_word_t want_word;

  function automatic logic take_press(input int b);
    logic change;
    begin
      change = 1'b0;
      if (since_press[b] >= cfg.repeat_ticks) begin
        since_press[b] = '0;
        change = (press_run[b] == '0) || (press_run[b] == REP_SAT);
        if (press_run[b] != REP_SAT) press_run[b] = press_run[b] + 1'b1;
      end
      return change;
    end
  endfunction

  task automatic predict_beat_tick(input logic down, input logic up);
    beat_word_t r;
    logic changed;
    logic [TEMPO_W-1:0] lim;
    int span;
    begin
      changed = 1'b0;
      r.toggled = 1'b0;
      lim = (cfg.bpm_max == '0) ? TEMPO_W'(1) : cfg.bpm_max;
      if (since_beat != '1) since_beat = since_beat + 1'b1;
      for (int b = 0; b < 2; b++) begin
        if (since_press[b] != '1) since_press[b] = since_press[b] + 1'b1;
      end
      if (combo_wait != '0) begin
        combo_wait = combo_wait - 1'b1;
      end else begin
        if (down && up) begin
          if (int'(bar_len) + 1 > int'(cfg.max_beats)) bar_len = BEATS_W'(1);
          else bar_len = bar_len + 1'b1;
          bar_step = '0;
          beat_phase = 1'b0;
          led_state = 2'b00;
          combo_wait = cfg.holdoff_ticks;
        end
        if (down) begin
          if (take_press(0) && tempo_now > 1) begin
            tempo_now = tempo_now - 1'b1;
            changed = 1'b1;
          end
        end else begin
          press_run[0] = '0;
        end
        if (up) begin
          if (take_press(1) && tempo_now < lim) begin
            tempo_now = tempo_now + 1'b1;
            changed = 1'b1;
          end
        end else begin
          press_run[1] = '0;
        end
        if (changed) half_beat = HALF_W'(HALF_MINUTE_TICKS_DEF / int'(tempo_now));
        if (since_beat >= half_beat) begin
          span = 2 * ((bar_len == '0) ? 1 : int'(bar_len));
          since_beat = '0;
          beat_phase = ~beat_phase;
          if (bar_step < 2) led_state[0] = beat_phase;
          else led_state[1] = beat_phase;
          bar_step = STEP_W'((int'(bar_step) + 1) % span);
          r.toggled = 1'b1;
        end
      end
      r.led_one = led_state[0];
      r.led_two = led_state[1];
      r.tempo = tempo_now;
      r.beats = bar_len;
      expected_beats.push_back(r);
    end
  endtask

  task automatic write_reg(input reg_idx_t r, input int unsigned value);
    logic [APB_DW-1:0] data;
    begin
      data = $urandom;
      case (r)
        REG_BPM_MAX: begin
          data[TEMPO_W-1:0] = TEMPO_W'(value);
          cfg.bpm_max = TEMPO_W'(value);
        end
        REG_REPEAT: begin
          data[PRESS_W-1:0] = PRESS_W'(value);
          cfg.repeat_ticks = PRESS_W'(value);
        end
        REG_HOLDOFF: begin
          data[HOLD_W-1:0] = HOLD_W'(value);
          cfg.holdoff_ticks = HOLD_W'(value);
        end
        REG_MAX_BEATS: begin
          data[BEATS_W-1:0] = BEATS_W'(value);
          cfg.max_beats = BEATS_W'(value);
        end
        default: begin
        end
      endcase
      @(posedge clk);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {r, 2'b00};
      pwdata <= data;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
    end
  endtask

  task automatic write_settings(input int unsigned bpm, input int unsigned rep,
                                input int unsigned hold, input int unsigned beats);
    begin
      write_reg(REG_BPM_MAX, bpm);
      write_reg(REG_REPEAT, rep);
      write_reg(REG_HOLDOFF, hold);
      write_reg(REG_MAX_BEATS, beats);
    end
  endtask

  task automatic hold_buttons(input logic down, input logic up, input int n);
    repeat (n) pending_words.push_back({down, up});
  endtask

  // Mostly real button gestures with random lengths, plus some noise.
  task automatic add_gestures(input int n);
    int pushed;
    int len;
    int kind;
    begin
      pushed = 0;
      while (pushed < n) begin
        kind = $urandom_range(0, 9);
        len = $urandom_range(1, 60);
        case (kind)
          0, 1, 2, 3: hold_buttons(1'b0, 1'b1, len);
          4, 5, 6: hold_buttons(1'b1, 1'b0, len);
          7: begin
            len = $urandom_range(1, 3);
            hold_buttons(1'b1, 1'b1, len);
          end
          8: begin
            len = $urandom_range(1, 10);
            repeat (len) pending_words.push_back(2'($urandom));
          end
          default: hold_buttons(1'b0, 1'b0, len);
        endcase
        pushed += len;
        if (kind < 7) begin
          len = $urandom_range(1, 3);
          hold_buttons(1'b0, 1'b0, len);
          pushed += len;
        end
      end
    end
  endtask

  task automatic wait_idle;
    while (pending_words.size() != 0 || in_valid || expected_beats.size() != 0)
      @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_button_down <= 1'b0;
      in_button_up <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_beat_tick(in_button_down, in_button_up);
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          next_word = pending_words.pop_front();
          in_valid <= 1'b1;
          in_button_down <= next_word.down;
          in_button_up <= next_word.up;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 400) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_word = {out_led_one, out_led_two, out_tempo, out_beats_per_bar, out_toggled};
        if (expected_beats.size() == 0) begin
          if (mismatches < 10)
            $display("result %0d arrived with no word outstanding", results_seen);
          mismatches++;
        end else begin
          want_word = expected_beats.pop_front();
          if (got_word !== want_word) begin
            if (mismatches < 10) begin
              $display("result %0d: expected led_one %b led_two %b tempo %0d beats %0d toggled %b",
                       results_seen, want_word.led_one, want_word.led_two, want_word.tempo,
                       want_word.beats, want_word.toggled);
              $display("result %0d: got led_one %b led_two %b tempo %0d beats %0d toggled %b",
                       results_seen, got_word.led_one, got_word.led_two, got_word.tempo,
                       got_word.beats, got_word.toggled);
            end
            mismatches++;
          end
        end
        results_seen <= results_seen + 1;
      end
      rx_cycle = rx_cycle + 1'b1;
      case (rx_cycle[8:7])
        2'd0: rx_go = 1'b1;
        2'd1: rx_go = 1'($urandom_range(0, 1));
        2'd2: rx_go = (rx_cycle[2:0] < 3'd5);
        default: rx_go = ($urandom_range(0, 9) != 0);
      endcase
      out_ready <= (hold_left == 0) && rx_go;
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    cfg = {BPM_MAX_RESET, REPEAT_RESET, HOLDOFF_RESET, MAX_BEATS_RESET};
    tempo_now = TEMPO_RESET;
    bar_len = BEATS_RESET;
    bar_step = '0;
    beat_phase = 1'b0;
    led_state = 2'b00;
    half_beat = HALF_W'(250);
    since_beat = '0;
    since_press[0] = '0;
    since_press[1] = '0;
    press_run[0] = '0;
    press_run[1] = '0;
    combo_wait = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Settings after reset: the first repeat accept comes after a full interval.
    hold_buttons(1'b0, 1'b1, 110);
    hold_buttons(1'b0, 1'b0, 10);
    wait_idle();

    // A zero tempo limit, zero repeat interval, no hold-off and zero max beats.
    write_settings(0, 0, 0, 0);
    hold_buttons(1'b1, 1'b1, 1);
    hold_buttons(1'b0, 1'b1, 2);
    hold_buttons(1'b1, 1'b0, 5);
    hold_buttons(1'b0, 1'b0, 1);
    hold_buttons(1'b1, 1'b1, 1);
    wait_idle();

    // Back-to-back combos walk the bar through every length and wrap.
    write_settings(1023, 1, 0, 15);
    hold_buttons(1'b1, 1'b1, 16);
    wait_idle();

    write_settings(1000, 0, 0, 15);
    hold_buttons(1'b1, 1'b0, 40);
    hold_buttons(1'b0, 1'b1, 100);
    add_gestures(80);
    wait_idle();

    write_settings(int'(tempo_now) + $urandom_range(5, 30), $urandom_range(0, 3),
                   $urandom_range(0, 15), $urandom_range(1, 15));
    add_gestures(80);
    wait_idle();

    write_settings(1, 1, 2, 3);
    add_gestures(60);
    wait_idle();

    write_settings(1000, 150, 100, 8);
    hold_buttons(1'b0, 1'b1, 160);
    hold_buttons(1'b1, 1'b1, 1);
    add_gestures(100);
    wait_idle();

    repeat (30) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: metronome_beat_controller.f
rtl/mbc_pkg.sv
rtl/mbc_div.sv
rtl/mbc_dp.sv
rtl/mbc_ctrl.sv
rtl/metronome_beat_controller.sv
rtl/mbc_checker.sv
tb/metronome_beat_controller_tb.sv
